FILE: hw/rtl/text_console_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Text console writer - assertion macros
// Shared macros for the concurrent checks on the console core.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Check sampled on clk and switched off while arst_n is low.
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check sampled on clk that must also hold during reset.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer - package
// Screen geometry, codes, beat types and the cell packing function.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 4;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int CLR_W  = 4;

	localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0] TAB_CODE   = 8'd9;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic {
		REG_BLANK_FG = 1'b0,
		REG_BLANK_BG = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_CLEAR,
		ST_RESP
	} state_t;

	typedef struct packed {
		opcode_t           opcode;
		logic [CHAR_W-1:0] char_code;
		logic [CLR_W-1:0]  fore_colour;
		logic [CLR_W-1:0]  back_colour;
		logic [10:0]       cell_address;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [CELL_W-1:0] cell_data;
		logic              scrolled;
	} result_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} ctrl_status_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic [CELL_W-1:0] make_cell(
		input logic [CHAR_W-1:0] code,
		input logic [CLR_W-1:0]  fg,
		input logic [CLR_W-1:0]  bg
	);
		return {bg, fg, code};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console writer - screen RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer - sequencer
// Cursor keeping, screen walks for scroll and clear, and RAM access control.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire item_t             item,
	input  wire logic [CELL_W-1:0] blank,
	input  wire logic              res_take,
	output ctrl_status_t           status,
	output result_t                result,
	output mem_req_t               mem_req,
	input  wire logic [CELL_W-1:0] mem_rdata
);

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

	state_t             state_q, state_d;
	item_t              item_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]  row_base_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic               scrolled_q;
	logic               in_range_q;
	logic               copy_v_s1;
	logic [ADDR_W-1:0]  copy_dst_s1;

	logic [COL_W-1:0]   tab_col;
	logic [COL_W-1:0]   new_col;
	logic               row_adv;
	logic               drawn;
	logic               need_scroll;
	logic               addr_ok;

	assign tab_col = COL_W'((int'(col_q) / TAB_STOP + 1) * TAB_STOP);
	assign drawn   = (item_q.char_code != NL_CODE) && (item_q.char_code != TAB_CODE);
	assign addr_ok = (int'(item_q.cell_address) < CELL_COUNT);

	// Column after a put-char, with the wrap at the end of the row folded in.
	always_comb begin
		new_col = col_q;
		row_adv = 1'b0;
		if (item_q.char_code == NL_CODE) begin
			new_col = '0;
			row_adv = 1'b1;
		end else if (item_q.char_code == TAB_CODE) begin
			new_col = tab_col;
		end else begin
			new_col = col_q + COL_W'(1);
		end
		if (int'(new_col) >= COLUMNS) begin
			new_col = '0;
			row_adv = 1'b1;
		end
	end

	assign need_scroll = row_adv && (int'(row_q) == ROWS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (item_q.opcode)
					OP_PUT:   state_d = need_scroll ? ST_COPY : ST_RESP;
					OP_CLEAR: state_d = ST_CLEAR;
					OP_READ:  state_d = ST_RESP;
					OP_NONE:  state_d = ST_RESP;
				endcase
			end
			ST_COPY: begin
				if (cnt_q == LAST_CELL) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!copy_v_s1 && cnt_q == LAST_CELL) begin
					state_d = ST_RESP;
				end
			end
			ST_CLEAR: begin
				if (cnt_q == LAST_CELL) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port use per state; a pending copy write outranks the row fill.
	always_comb begin
		mem_req = '0;
		status  = '0;
		unique case (state_q)
			ST_IDLE: status.idle = 1'b1;
			ST_EXEC: begin
				if (item_q.opcode == OP_PUT && drawn) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = row_base_q + ADDR_W'(col_q);
					mem_req.wdata = make_cell(item_q.char_code, item_q.fore_colour,
						item_q.back_colour);
				end
				if (item_q.opcode == OP_READ && addr_ok) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_W'(item_q.cell_address);
				end
			end
			ST_COPY: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_q;
			end
			ST_FILL: begin
				if (!copy_v_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cnt_q;
					mem_req.wdata = blank;
				end
			end
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
				mem_req.wdata = blank;
			end
			ST_RESP: status.res_valid = 1'b1;
			default: status = '0;
		endcase
		if (copy_v_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = copy_dst_s1;
			mem_req.wdata = mem_rdata;
		end
	end

	always_comb begin
		result.cursor_position = POS_W'(row_base_q + ADDR_W'(col_q));
		result.cell_data       = (item_q.opcode == OP_READ && in_range_q) ? mem_rdata : '0;
		result.scrolled        = scrolled_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			copy_v_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			copy_v_s1 <= (state_q == ST_COPY);
			if (state_q == ST_EXEC && item_q.opcode == OP_PUT) begin
				col_q <= new_col;
				if (row_adv && !need_scroll) begin
					row_q      <= row_q + ROW_W'(1);
					row_base_q <= row_base_q + ROW_STEP;
				end
			end else if (state_q == ST_EXEC && item_q.opcode == OP_CLEAR) begin
				col_q      <= '0;
				row_q      <= '0;
				row_base_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
		copy_dst_s1 <= cnt_q - ROW_STEP;
		unique case (state_q)
			ST_EXEC: begin
				scrolled_q <= (item_q.opcode == OP_PUT) && need_scroll;
				in_range_q <= addr_ok;
				cnt_q      <= (item_q.opcode == OP_CLEAR) ? '0 : ROW_STEP;
			end
			ST_COPY:  cnt_q <= (cnt_q == LAST_CELL) ? LAST_ROW : cnt_q + ADDR_W'(1);
			ST_FILL: begin
				if (!copy_v_s1) begin
					cnt_q <= cnt_q + ADDR_W'(1);
				end
			end
			ST_CLEAR: cnt_q <= cnt_q + ADDR_W'(1);
			default: cnt_q <= cnt_q;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer_core.sv
// A text-mode console engine. It holds a screen of 80 x 25 cells of 16 bits
// (character in bits 7..0, foreground in 11..8, background in 15..12) in one
// single-port-write, registered-read RAM, together with a cursor. Each input
// beat carries an opcode: put character (newline, tab to the next multiple
// of four, or a drawn character written at the cursor), clear screen, or read
// cell; opcode 3 does nothing. Every input beat yields exactly one output
// beat with the cursor position after the operation, the cell read (zero for
// anything but a read) and a flag set when a put-char scrolled the screen.
// Items are handled one at a time: a put-char, read or no-op passes from
// acceptance through a decode state that also does the RAM write or read, a
// state that hands the result to the output register once that register can
// take it, and back to idle, in which the next beat is taken.
// A scroll copies every row up by one and fills the bottom row with blank
// cells, and a clear writes a blank to every cell, each by walking the
// screen through the one RAM write port. The output register lets a result
// wait for the consumer while the next item is already taken in. The screen
// RAM is not initialised; a clear must be issued before any other use. The
// blank cell colours for clear and scroll are set over the register port; the
// user must do so only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// Text console writer - top level
// Stream ports, configuration registers, output register and the screen RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core
	import tcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input beats.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: char_code[7:0], fore_colour[11:8], back_colour[15:12],
	// cell_address[26:16], zero fill above.
	input  wire logic [31:0] s_axis_tdata,
	// tuser: opcode[1:0].
	input  wire logic [1:0]  s_axis_tuser,
	// Result beats.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: cursor_position[10:0], cell_data[26:11], scrolled[27], zero fill above.
	output logic [31:0]      m_axis_tdata,
	// Register port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CLR_W-1:0]  blank_fg_q;
	logic [CLR_W-1:0]  blank_bg_q;
	logic [CELL_W-1:0] blank;
	logic              cfg_wr;
	reg_index_t        reg_sel;

	item_t             item;
	logic              start;
	ctrl_status_t      status;
	result_t           result;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rdata;
	logic              res_take;

	logic              out_valid_q;
	result_t           out_q;

	// Register port: every access completes at once, registers are 4 bytes apart.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_index_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_BLANK_FG: prdata = {28'd0, blank_fg_q};
			REG_BLANK_BG: prdata = {28'd0, blank_bg_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_fg_q <= 4'd15;
			blank_bg_q <= 4'd1;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_BLANK_FG: blank_fg_q <= pwdata[CLR_W-1:0];
				REG_BLANK_BG: blank_bg_q <= pwdata[CLR_W-1:0];
			endcase
		end
	end

	// A blank cell is a space in the configured colours.
	assign blank = make_cell(SPACE_CODE, blank_fg_q, blank_bg_q);

	// Input beat unpacking; the sequencer captures it on acceptance.
	assign item.opcode       = opcode_t'(s_axis_tuser);
	assign item.char_code    = s_axis_tdata[7:0];
	assign item.fore_colour  = s_axis_tdata[11:8];
	assign item.back_colour  = s_axis_tdata[15:12];
	assign item.cell_address = s_axis_tdata[26:16];

	assign s_axis_tready = status.idle;
	assign start         = s_axis_tvalid && s_axis_tready;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.blank     (blank),
		.res_take  (res_take),
		.status    (status),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tcw_ram #(
		.DEPTH (CELL_COUNT),
		.WIDTH (CELL_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Output register: a result moves in when the register is empty or is
	// being emptied in the same cycle.
	assign res_take = status.res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.scrolled, out_q.cell_data, out_q.cursor_position};

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer - port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_core_defines.svh"

module tcw_checker
	import tcw_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	// A held result keeps its payload until taken.
	`TCW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// The reported cursor always lies on the screen.
	`TCW_ASSERT_ALWAYS(a_cursor_range, m_axis_tvalid |-> (int'(m_axis_tdata[10:0]) < CELL_COUNT), "cursor beyond the screen")

	// After a scroll the cursor sits on the bottom row.
	`TCW_ASSERT(a_scroll_row, m_axis_tvalid && m_axis_tdata[27] |-> (int'(m_axis_tdata[10:0]) >= (ROWS - 1) * COLUMNS), "scroll left the cursor above the bottom row")

	// Items are taken one at a time: no acceptance on the cycle after one.
	`TCW_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in progress")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

`default_nettype wire
